/* rtl/dlts_pkg.sv */
`timescale 1ns / 1ps
// Shared types and codes for the delta-list task scheduler.
// No dependencies.
package dlts_pkg;

	localparam logic [1:0] REQ_TICK     = 2'd0;
	localparam logic [1:0] REQ_ADD      = 2'd1;
	localparam logic [1:0] REQ_DELETE   = 2'd2;
	localparam logic [1:0] REQ_DISPATCH = 2'd3;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	localparam int HANDLE_W = 8;
	localparam int DELTA_W  = 16;
	localparam int RUNS_W   = 8;
	localparam int ID_W     = 6;

	localparam logic [RUNS_W-1:0]  RUNS_MAX  = '1;
	localparam logic [DELTA_W-1:0] DELTA_MAX = '1;

	typedef struct packed {
		logic [HANDLE_W-1:0] handle;
		logic [DELTA_W-1:0]  delta;
		logic [DELTA_W-1:0]  period;
		logic [RUNS_W-1:0]   runs;
		logic [ID_W-1:0]     id;
	} entry_t;

	typedef struct packed {
		logic                push;
		logic [HANDLE_W-1:0] handle;
		logic [ID_W-1:0]     id;
		logic                rd;
	} fifo_ctl_t;

endpackage

/* rtl/dlts_run_fifo.sv */
`timescale 1ns / 1ps
// Run queue of tasks handed out by dispatch: circular buffer with registered read.
// Depends on dlts_pkg.
module dlts_run_fifo #(
	parameter int DEPTH = 4
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  dlts_pkg::fifo_ctl_t           ctl,
	output logic                          not_full,
	output logic                          not_empty,
	output logic [dlts_pkg::HANDLE_W-1:0] rd_handle,
	output logic [dlts_pkg::ID_W-1:0]     rd_id
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

	logic [dlts_pkg::HANDLE_W+dlts_pkg::ID_W-1:0] mem [DEPTH];
	logic [PW-1:0] head_q, tail_q;
	logic [CW-1:0] cnt_q;
	logic [dlts_pkg::HANDLE_W+dlts_pkg::ID_W-1:0] rd_q;

	assign not_full  = (cnt_q != CW'(DEPTH));
	assign not_empty = (cnt_q != '0);
	assign rd_handle = rd_q[dlts_pkg::HANDLE_W+dlts_pkg::ID_W-1:dlts_pkg::ID_W];
	assign rd_id     = rd_q[dlts_pkg::ID_W-1:0];

	always_ff @(posedge clk) begin
		if (ctl.push && not_full) begin
			mem[tail_q] <= {ctl.handle, ctl.id};
		end
		if (ctl.rd) begin
			rd_q <= mem[head_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (ctl.push && not_full) begin
				tail_q <= (tail_q == LAST) ? '0 : tail_q + 1'b1;
				cnt_q  <= cnt_q + 1'b1;
			end else if (ctl.rd && not_empty) begin
				head_q <= (head_q == LAST) ? '0 : head_q + 1'b1;
				cnt_q  <= cnt_q - 1'b1;
			end
		end
	end

endmodule

/* rtl/delta_list_task_scheduler_unit.sv */
`timescale 1ns / 1ps
// Delta-list task scheduler: sequencer around the task list memory.
// Depends on dlts_pkg and dlts_run_fifo.
//
// Usage: drive req_type and its operands with start high while busy is low;
// the request is taken at that clock edge and busy rises, unless the request
// is answered from idle (a tick on an empty list, an add to a full list or a
// delete past the count). Exactly one result per request comes back on the
// result ports, marked by done for one cycle. The receiver cannot stall; take
// the result in the done cycle. A new request may be issued in the done cycle
// itself. A tick updates the head; a delete shifts the entries after the
// position up; an add walks to the slot, then shifts the tail down; a dispatch
// removes a due head, re-inserts it if periodic, and reads the run queue.
// The list memory has one read and one write port with a registered read; a
// read of the entry written in the same cycle returns the new data. The walk
// reads and the shifts move one entry a cycle. Reset clears the list count,
// the run queue pointers and the carried id and runs; entries beyond the
// count are never read, so the list memory needs no clearing pass.
module delta_list_task_scheduler_unit #(
	parameter int MAX_TASKS       = 32,
	parameter int RUN_QUEUE_DEPTH = 4
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [1:0]                    req_type,
	input  logic [7:0]                    task_handle,
	input  logic [15:0]                   delay,
	input  logic [15:0]                   period,
	input  logic [4:0]                    position,
	output logic                          done,
	output logic                          run_valid,
	output logic [7:0]                    run_handle,
	output logic [5:0]                    run_task_id,
	output logic [1:0]                    status,
	output logic [5:0]                    slot_index,
	output logic [5:0]                    task_count
);
	localparam int AW = $clog2(MAX_TASKS);
	localparam int CW = $clog2(MAX_TASKS + 1);
	localparam int TW = dlts_pkg::DELTA_W + CW;
	localparam int QW = (CW > 5) ? CW : 5;

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_TICK  = 4'd1;
	localparam logic [3:0] S_DELH  = 4'd2;
	localparam logic [3:0] S_SHUP  = 4'd3;
	localparam logic [3:0] S_WALK  = 4'd4;
	localparam logic [3:0] S_SHDN  = 4'd5;
	localparam logic [3:0] S_INS   = 4'd6;
	localparam logic [3:0] S_DISP  = 4'd7;
	localparam logic [3:0] S_FRD   = 4'd8;
	localparam logic [3:0] S_FOUT  = 4'd9;

	// task list memory
	dlts_pkg::entry_t mem [MAX_TASKS];
	dlts_pkg::entry_t rdata_q;
	logic             mem_re, mem_we;
	logic [AW-1:0]    mem_ra, mem_wa;
	dlts_pkg::entry_t mem_wd;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (mem_re) begin
			// forward the entry being written in the same cycle
			rdata_q <= (mem_we && mem_wa == mem_ra) ? mem_wd : mem[mem_ra];
		end
	end

	// run queue
	dlts_pkg::fifo_ctl_t fctl;
	logic                f_not_full, f_not_empty;
	logic [7:0]          f_handle;
	logic [5:0]          f_id;

	dlts_run_fifo #(.DEPTH(RUN_QUEUE_DEPTH)) u_fifo (
		.clk(clk), .arst_n(arst_n), .ctl(fctl),
		.not_full(f_not_full), .not_empty(f_not_empty),
		.rd_handle(f_handle), .rd_id(f_id)
	);

	// sequencer registers
	logic [3:0]    state_q, state_n;
	logic [1:0]    op_q, op_n;
	logic [7:0]    hdl_q, hdl_n;
	logic [15:0]   dly_q, dly_n, per_q, per_n;
	logic [CW-1:0] pos_q, pos_n, count_q, count_n, idx_q, idx_n, slot_q, slot_n;
	logic [5:0]    cid_q, cid_n;
	logic [7:0]    cruns_q, cruns_n;
	logic [TW-1:0] sum_q, sum_n, before_q, before_n;
	logic [15:0]   brk_q, brk_n, del_q, del_n;
	logic          reins_q, reins_n;
	logic          done_q, done_n, rv_q, rv_n;
	logic [7:0]    rh_q, rh_n;
	logic [5:0]    rid_q, rid_n, so_q, so_n;
	logic [1:0]    st_q, st_n;

	assign busy        = (state_q != S_IDLE);
	assign done        = done_q;
	assign run_valid   = rv_q;
	assign run_handle  = rh_q;
	assign run_task_id = rid_q;
	assign status      = st_q;
	assign slot_index  = so_q;
	assign task_count  = 6'(count_q);

	logic          rem_done, ins_go;
	logic [CW-1:0] ins_cnt;
	logic [TW-1:0] tot;
	logic [16:0]   sat_sum;
	logic [15:0]   dec_delta;

	always_comb begin
		state_n = state_q; op_n = op_q; hdl_n = hdl_q; dly_n = dly_q; per_n = per_q;
		pos_n = pos_q; count_n = count_q; idx_n = idx_q; slot_n = slot_q;
		cid_n = cid_q; cruns_n = cruns_q; sum_n = sum_q; before_n = before_q;
		brk_n = brk_q; del_n = del_q; reins_n = reins_q;
		done_n = 1'b0; rv_n = rv_q; rh_n = rh_q; rid_n = rid_q; so_n = so_q; st_n = st_q;
		mem_re = 1'b0; mem_ra = '0; mem_we = 1'b0; mem_wa = '0; mem_wd = rdata_q;
		fctl = '0;
		rem_done = 1'b0; ins_go = 1'b0; ins_cnt = count_q;
		tot = sum_q + TW'(rdata_q.delta);
		sat_sum = {1'b0, del_q} + {1'b0, rdata_q.delta};
		dec_delta = (rdata_q.delta != '0) ? rdata_q.delta - 1'b1 : '0;

		case (state_q)
			S_IDLE: begin
				if (start) begin
					op_n = req_type; hdl_n = task_handle; dly_n = delay; per_n = period;
					pos_n = CW'(position); reins_n = 1'b0;
					rv_n = 1'b0; rh_n = '0; rid_n = '0; so_n = '0; st_n = dlts_pkg::ST_OK;
					case (req_type)
						dlts_pkg::REQ_TICK: begin
							if (count_q == '0) begin
								done_n = 1'b1;
							end else begin
								mem_re = 1'b1; state_n = S_TICK;
							end
						end
						dlts_pkg::REQ_ADD: begin
							if (count_q >= CW'(MAX_TASKS)) begin
								st_n = dlts_pkg::ST_FULL; so_n = 6'(MAX_TASKS); done_n = 1'b1;
							end else begin
								ins_go = 1'b1;
							end
						end
						dlts_pkg::REQ_DELETE: begin
							if (QW'(position) >= QW'(count_q)) begin
								st_n = dlts_pkg::ST_EMPTY; done_n = 1'b1;
							end else begin
								mem_re = 1'b1; mem_ra = AW'(position); idx_n = CW'(position);
								state_n = S_DELH;
							end
						end
						default: begin
							if (count_q == '0) begin
								state_n = S_FRD;
							end else begin
								mem_re = 1'b1; state_n = S_DISP;
							end
						end
					endcase
				end
			end
			S_TICK: begin
				// count down the head, stopping at zero; a due head gains one pending run, saturating
				mem_we = 1'b1;
				mem_wd.delta = dec_delta;
				if (dec_delta == '0 && rdata_q.runs != dlts_pkg::RUNS_MAX) begin
					mem_wd.runs = rdata_q.runs + 1'b1;
				end
				done_n = 1'b1; state_n = S_IDLE;
			end
			S_DELH: begin
				if (rdata_q.period != '0) cid_n = rdata_q.id;
				del_n = rdata_q.delta;
				if (idx_q + 1'b1 < count_q) begin
					mem_re = 1'b1; mem_ra = AW'(idx_q + 1'b1); idx_n = idx_q + 1'b1;
					state_n = S_SHUP;
				end else begin
					rem_done = 1'b1;
				end
			end
			S_SHUP: begin
				// move entry up one slot; the successor of the hole adds its delta, saturating
				mem_we = 1'b1; mem_wa = AW'(idx_q - 1'b1);
				if (idx_q == pos_q + 1'b1) begin
					mem_wd.delta = sat_sum[16] ? dlts_pkg::DELTA_MAX : sat_sum[15:0];
				end
				if (idx_q + 1'b1 == count_q) begin
					rem_done = 1'b1;
				end else begin
					mem_re = 1'b1; mem_ra = AW'(idx_q + 1'b1); idx_n = idx_q + 1'b1;
				end
			end
			S_WALK: begin
				if (tot > TW'(dly_q)) begin
					slot_n = idx_q; before_n = sum_q; brk_n = 16'(tot - TW'(dly_q));
					mem_re = 1'b1; mem_ra = AW'(count_q - 1'b1); idx_n = count_q - 1'b1;
					state_n = S_SHDN;
				end else begin
					sum_n = tot;
					if (idx_q + 1'b1 == count_q) begin
						slot_n = count_q; before_n = tot; state_n = S_INS;
					end else begin
						mem_re = 1'b1; mem_ra = AW'(idx_q + 1'b1); idx_n = idx_q + 1'b1;
					end
				end
			end
			S_SHDN: begin
				// move entry down one slot; the displaced entry keeps the remainder
				mem_we = 1'b1; mem_wa = AW'(idx_q + 1'b1);
				if (idx_q == slot_q) begin
					mem_wd.delta = brk_q;
					state_n = S_INS;
				end else begin
					mem_re = 1'b1; mem_ra = AW'(idx_q - 1'b1); idx_n = idx_q - 1'b1;
				end
			end
			S_INS: begin
				mem_we = 1'b1; mem_wa = AW'(slot_q);
				mem_wd.handle = hdl_q;
				mem_wd.delta  = 16'(TW'(dly_q) - before_q);
				mem_wd.period = per_q;
				mem_wd.runs   = cruns_q;
				mem_wd.id     = (cid_q != '0) ? cid_q : 6'(count_q + 1'b1);
				count_n = count_q + 1'b1;
				cid_n = '0; cruns_n = '0;
				if (op_q == dlts_pkg::REQ_ADD) begin
					so_n = 6'(slot_q); done_n = 1'b1; state_n = S_IDLE;
				end else begin
					state_n = S_FRD;
				end
			end
			S_DISP: begin
				if (rdata_q.delta == '0 && rdata_q.runs != '0) begin
					fctl.push = 1'b1; fctl.handle = rdata_q.handle; fctl.id = rdata_q.id;
					if (rdata_q.period != '0) begin
						cruns_n = rdata_q.runs - 1'b1;
						cid_n = rdata_q.id;
					end
					hdl_n = rdata_q.handle; per_n = rdata_q.period; dly_n = rdata_q.period;
					reins_n = (rdata_q.period != '0);
					del_n = '0; pos_n = '0;
					if (count_q > CW'(1)) begin
						mem_re = 1'b1; mem_ra = AW'(1); idx_n = CW'(1); state_n = S_SHUP;
					end else begin
						rem_done = 1'b1;
					end
				end else begin
					state_n = S_FRD;
				end
			end
			S_FRD: begin
				if (f_not_empty) begin
					fctl.rd = 1'b1; state_n = S_FOUT;
				end else begin
					done_n = 1'b1; state_n = S_IDLE;
				end
			end
			S_FOUT: begin
				rv_n = 1'b1; rh_n = f_handle; rid_n = f_id;
				done_n = 1'b1; state_n = S_IDLE;
			end
			default: begin
				state_n = S_IDLE;
			end
		endcase

		// finish a removal: drop the count, then report, re-insert or read the run queue
		if (rem_done) begin
			count_n = count_q - 1'b1;
			if (op_q == dlts_pkg::REQ_DELETE) begin
				done_n = 1'b1; state_n = S_IDLE;
			end else if (reins_q || reins_n) begin
				ins_go = 1'b1; ins_cnt = count_q - 1'b1;
			end else begin
				state_n = S_FRD;
			end
		end

		// begin an insertion walk from the head, or insert directly into an empty list
		if (ins_go) begin
			sum_n = '0;
			if (ins_cnt == '0) begin
				slot_n = '0; before_n = '0; state_n = S_INS;
			end else begin
				mem_re = 1'b1; mem_ra = '0; idx_n = '0; state_n = S_WALK;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			cid_q   <= '0;
			cruns_q <= '0;
			done_q  <= 1'b0;
			reins_q <= 1'b0;
			rv_q    <= 1'b0;
			rh_q    <= '0;
			rid_q   <= '0;
			so_q    <= '0;
			st_q    <= dlts_pkg::ST_OK;
		end else begin
			state_q <= state_n;
			count_q <= count_n;
			cid_q   <= cid_n;
			cruns_q <= cruns_n;
			done_q  <= done_n;
			reins_q <= reins_n;
			rv_q    <= rv_n;
			rh_q    <= rh_n;
			rid_q   <= rid_n;
			so_q    <= so_n;
			st_q    <= st_n;
		end
	end

	always_ff @(posedge clk) begin
		op_q     <= op_n;
		hdl_q    <= hdl_n;
		dly_q    <= dly_n;
		per_q    <= per_n;
		pos_q    <= pos_n;
		idx_q    <= idx_n;
		slot_q   <= slot_n;
		sum_q    <= sum_n;
		before_q <= before_n;
		brk_q    <= brk_n;
		del_q    <= del_n;
	end

endmodule

/* verif/tb_delta_list_task_scheduler_unit.sv */
`timescale 1ns / 1ps
// Self-checking bench for the delta-list task scheduler: directed requests, then random bursts,
// each result checked against a cycle-free predictor. Depends on dlts_pkg and the RTL.
module tb_delta_list_task_scheduler_unit;

	localparam int SLOTS      = 32;
	localparam int RUN_DEPTH  = 4;
	localparam int ITEM_GOAL  = 1350;
	localparam int CYCLE_CAP  = 2000000;

	typedef struct {
		logic [1:0]  req;
		logic [7:0]  handle;
		logic [15:0] dly;
		logic [15:0] per;
		logic [4:0]  pos;
	} request_t;

	typedef struct {
		logic       run_valid;
		logic [7:0] run_handle;
		logic [5:0] run_id;
		logic [1:0] status;
		logic [5:0] slot;
		logic [5:0] count;
	} outcome_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [1:0]  req_type;
	logic [7:0]  task_handle;
	logic [15:0] delay;
	logic [15:0] period;
	logic [4:0]  position;
	logic        done;
	logic        run_valid;
	logic [7:0]  run_handle;
	logic [5:0]  run_task_id;
	logic [1:0]  status;
	logic [5:0]  slot_index;
	logic [5:0]  task_count;

	delta_list_task_scheduler_unit #(
		.MAX_TASKS(SLOTS),
		.RUN_QUEUE_DEPTH(RUN_DEPTH)
	) u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.req_type(req_type), .task_handle(task_handle), .delay(delay),
		.period(period), .position(position), .done(done),
		.run_valid(run_valid), .run_handle(run_handle), .run_task_id(run_task_id),
		.status(status), .slot_index(slot_index), .task_count(task_count)
	);

	// Shadow copy of the scheduler state
	logic [7:0]  sh_handle [SLOTS];
	logic [15:0] sh_delta  [SLOTS];
	logic [15:0] sh_period [SLOTS];
	logic [7:0]  sh_runs   [SLOTS];
	logic [5:0]  sh_id     [SLOTS];
	int          sh_count;
	logic [7:0]  q_handle [RUN_DEPTH];
	logic [5:0]  q_id     [RUN_DEPTH];
	int          q_count;
	logic [5:0]  held_id;
	logic [7:0]  held_runs;

	request_t pending_reqs[$];
	outcome_t expected_outcomes[$];

	int  mismatches = 0;
	int  cycles = 0;
	int  accepted_total = 0;
	int  runs_handed = 0;
	int  full_hits = 0;
	int  empty_deletes = 0;
	int  burst_left = 0;
	int  gap_left = 0;
	bit  took_item = 0;

	// Remove one list entry; its delta passes on to the successor, saturating.
	function automatic void drop_entry(int pos);
		logic [16:0] sum;
		if (sh_period[pos] != 0)
			held_id = sh_id[pos];
		if (pos + 1 < sh_count) begin
			sum = sh_delta[pos] + sh_delta[pos + 1];
			sh_delta[pos + 1] = sum[16] ? 16'hFFFF : sum[15:0];
		end
		for (int i = pos; i + 1 < sh_count; i++) begin
			sh_handle[i] = sh_handle[i + 1];
			sh_delta[i]  = sh_delta[i + 1];
			sh_period[i] = sh_period[i + 1];
			sh_runs[i]   = sh_runs[i + 1];
			sh_id[i]     = sh_id[i + 1];
		end
		sh_handle[sh_count - 1] = '0;
		sh_delta[sh_count - 1]  = '0;
		sh_period[sh_count - 1] = '0;
		sh_runs[sh_count - 1]   = '0;
		sh_id[sh_count - 1]     = '0;
		sh_count--;
	endfunction

	// Walk the running delta sum to the first entry due later, then shift the tail down.
	function automatic int place_task(logic [7:0] h, logic [15:0] d, logic [15:0] p);
		int prior = 0;
		int total = 0;
		int slot = sh_count;
		for (int i = 0; i < sh_count; i++) begin
			prior = total;
			total += sh_delta[i];
			if (total > d) begin
				slot = i;
				break;
			end
		end
		if (slot == sh_count)
			prior = total;
		for (int i = sh_count; i > slot; i--) begin
			sh_handle[i] = sh_handle[i - 1];
			sh_delta[i]  = sh_delta[i - 1];
			sh_period[i] = sh_period[i - 1];
			sh_runs[i]   = sh_runs[i - 1];
			sh_id[i]     = sh_id[i - 1];
		end
		sh_count++;
		sh_handle[slot] = h;
		sh_delta[slot]  = 16'(d - prior);
		sh_period[slot] = p;
		sh_runs[slot]   = held_runs;
		sh_id[slot]     = (held_id != 0) ? held_id : 6'(sh_count);
		if (slot + 1 < sh_count)
			sh_delta[slot + 1] = sh_delta[slot + 1] - sh_delta[slot];
		held_runs = '0;
		held_id   = '0;
		return slot;
	endfunction

	function automatic outcome_t schedule_step(request_t r);
		outcome_t o;
		logic [7:0]  h;
		logic [15:0] p;
		int          s;
		o = '{default: '0};
		case (r.req)
			dlts_pkg::REQ_TICK: begin
				if (sh_count > 0) begin
					if (sh_delta[0] > 0)
						sh_delta[0]--;
					if (sh_delta[0] == 0 && sh_runs[0] != dlts_pkg::RUNS_MAX)
						sh_runs[0]++;
				end
			end
			dlts_pkg::REQ_ADD: begin
				if (sh_count >= SLOTS) begin
					o.status = dlts_pkg::ST_FULL;
					o.slot   = 6'(SLOTS);
					full_hits++;
				end else begin
					s = place_task(r.handle, r.dly, r.per);
					o.slot = 6'(s);
				end
			end
			dlts_pkg::REQ_DELETE: begin
				if (r.pos >= sh_count) begin
					o.status = dlts_pkg::ST_EMPTY;
					empty_deletes++;
				end else begin
					drop_entry(r.pos);
				end
			end
			default: begin
				if (sh_count > 0 && sh_delta[0] == 0 && sh_runs[0] > 0) begin
					h = sh_handle[0];
					p = sh_period[0];
					if (q_count < RUN_DEPTH) begin
						q_handle[q_count] = h;
						q_id[q_count]     = sh_id[0];
						q_count++;
					end
					sh_runs[0]--;
					if (p != 0)
						held_runs = sh_runs[0];
					drop_entry(0);
					if (p != 0)
						void'(place_task(h, p, p));
				end
				if (q_count > 0) begin
					o.run_valid  = 1'b1;
					o.run_handle = q_handle[0];
					o.run_id     = q_id[0];
					for (int i = 0; i + 1 < q_count; i++) begin
						q_handle[i] = q_handle[i + 1];
						q_id[i]     = q_id[i + 1];
					end
					q_count--;
					q_handle[q_count] = '0;
					q_id[q_count]     = '0;
				end
			end
		endcase
		o.count = 6'(sh_count);
		return o;
	endfunction

	function automatic request_t mk(logic [1:0] rq, logic [7:0] h, logic [15:0] d,
			logic [15:0] p, logic [4:0] ps);
		request_t r;
		r.req = rq; r.handle = h; r.dly = d; r.per = p; r.pos = ps;
		return r;
	endfunction

	// Random operand values; the fields not used by a request still get random bits.
	function automatic request_t random_req(logic [1:0] rq);
		request_t r;
		r.req    = rq;
		r.handle = 8'($urandom);
		r.dly    = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 6));
		case ($urandom_range(0, 9))
			0, 1, 2: r.per = '0;
			3:       r.per = 16'($urandom);
			default: r.per = 16'($urandom_range(1, 5));
		endcase
		r.pos = ($urandom_range(0, 4) == 0) ? 5'($urandom) : 5'($urandom_range(0, 6));
		return r;
	endfunction

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hold reset while the request list is built, then release it.
	initial begin
		int n;
		arst_n      = 1'b0;
		start       = 1'b0;
		req_type    = dlts_pkg::REQ_TICK;
		task_handle = '0;
		delay       = '0;
		period      = '0;
		position    = '0;
		sh_handle = '{default: '0};
		sh_delta  = '{default: '0};
		sh_period = '{default: '0};
		sh_runs   = '{default: '0};
		sh_id     = '{default: '0};
		q_handle  = '{default: '0};
		q_id      = '{default: '0};
		sh_count = 0; q_count = 0; held_id = '0; held_runs = '0;

		// Directed: empty-list corners, field extremes, periodic reinsertion
		// and id reuse after a delete.
		pending_reqs.push_back(mk(dlts_pkg::REQ_TICK, 8'h00, 16'h0000, 16'h0000, 5'd0));
		pending_reqs.push_back(mk(dlts_pkg::REQ_DISPATCH, 8'hFF, 16'hFFFF, 16'hFFFF, 5'd31));
		pending_reqs.push_back(mk(dlts_pkg::REQ_DELETE, 8'h00, 16'h0000, 16'h0000, 5'd0));
		pending_reqs.push_back(mk(dlts_pkg::REQ_DELETE, 8'hFF, 16'hFFFF, 16'hFFFF, 5'd31));
		pending_reqs.push_back(mk(dlts_pkg::REQ_ADD, 8'hFF, 16'd40000, 16'hFFFF, 5'd31));
		pending_reqs.push_back(mk(dlts_pkg::REQ_ADD, 8'h00, 16'hFFFF, 16'h0000, 5'd0));
		pending_reqs.push_back(mk(dlts_pkg::REQ_DELETE, 8'h00, 16'h0000, 16'h0000, 5'd0));
		pending_reqs.push_back(mk(dlts_pkg::REQ_ADD, 8'hA5, 16'd0, 16'd2, 5'd0));
		pending_reqs.push_back(mk(dlts_pkg::REQ_ADD, 8'h5A, 16'd1, 16'd0, 5'd0));
		pending_reqs.push_back(mk(dlts_pkg::REQ_TICK, 8'h00, 16'h0000, 16'h0000, 5'd0));
		pending_reqs.push_back(mk(dlts_pkg::REQ_TICK, 8'h00, 16'h0000, 16'h0000, 5'd0));
		pending_reqs.push_back(mk(dlts_pkg::REQ_DISPATCH, 8'h00, 16'h0000, 16'h0000, 5'd0));
		pending_reqs.push_back(mk(dlts_pkg::REQ_TICK, 8'h00, 16'h0000, 16'h0000, 5'd0));
		pending_reqs.push_back(mk(dlts_pkg::REQ_DISPATCH, 8'h00, 16'h0000, 16'h0000, 5'd0));
		pending_reqs.push_back(mk(dlts_pkg::REQ_DISPATCH, 8'h00, 16'h0000, 16'h0000, 5'd0));
		pending_reqs.push_back(mk(dlts_pkg::REQ_DELETE, 8'h00, 16'h0000, 16'h0000, 5'd1));
		pending_reqs.push_back(mk(dlts_pkg::REQ_DELETE, 8'h00, 16'h0000, 16'h0000, 5'd0));
		pending_reqs.push_back(mk(dlts_pkg::REQ_ADD, 8'h3C, 16'd2, 16'd1, 5'd0));
		pending_reqs.push_back(mk(dlts_pkg::REQ_DELETE, 8'h00, 16'h0000, 16'h0000, 5'd0));
		pending_reqs.push_back(mk(dlts_pkg::REQ_ADD, 8'hC3, 16'd0, 16'd3, 5'd0));

		// Random: mostly single requests, with bursts that fill the list past
		// its limit, long tick runs that saturate the run count, and drains.
		n = pending_reqs.size();
		while (n < ITEM_GOAL) begin
			case ($urandom_range(0, 39))
				0: begin
					repeat (34) pending_reqs.push_back(random_req(dlts_pkg::REQ_ADD));
					repeat (20) pending_reqs.push_back(random_req(dlts_pkg::REQ_DELETE));
					n += 54;
				end
				1: begin
					repeat (260) pending_reqs.push_back(random_req(dlts_pkg::REQ_TICK));
					n += 260;
				end
				2, 3: begin
					repeat (12) pending_reqs.push_back(random_req(dlts_pkg::REQ_DELETE));
					n += 12;
				end
				default: begin
					pending_reqs.push_back(random_req(2'($urandom_range(0, 3))));
					n++;
				end
			endcase
		end

		repeat (3) @(negedge clk);
		arst_n = 1'b1;
	end

	// Driver: advance on each accepted item; work in bursts with random gaps.
	always @(negedge clk) begin
		logic     next_start;
		request_t r;
		next_start = start;
		if (arst_n) begin
			if (took_item) begin
				void'(pending_reqs.pop_front());
				next_start = 1'b0;
			end
			if (!next_start) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (pending_reqs.size() > 0) begin
					r = pending_reqs[0];
					req_type    <= r.req;
					task_handle <= r.handle;
					delay       <= r.dly;
					period      <= r.per;
					position    <= r.pos;
					next_start  = 1'b1;
					if (burst_left == 0) begin
						burst_left = $urandom_range(1, 40);
					end
					burst_left--;
					if (burst_left == 0)
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
				end
			end
		end
		start <= next_start;
	end

	// Monitor: check the done result first, then predict any item taken at this edge.
	always @(posedge clk) begin
		outcome_t want;
		request_t r;
		bit       take;
		cycles++;
		take = 1'b0;
		if (done) begin
			if (expected_outcomes.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("[%0t] result with nothing outstanding", $time);
			end else begin
				want = expected_outcomes.pop_front();
				if (run_valid !== want.run_valid || run_handle !== want.run_handle ||
						run_task_id !== want.run_id || status !== want.status ||
						slot_index !== want.slot || task_count !== want.count) begin
					mismatches++;
					if (mismatches <= 10)
						$display("[%0t] expected v=%0d h=%0d id=%0d st=%0d slot=%0d n=%0d, got v=%0d h=%0d id=%0d st=%0d slot=%0d n=%0d",
							$time, want.run_valid, want.run_handle, want.run_id,
							want.status, want.slot, want.count, run_valid, run_handle,
							run_task_id, status, slot_index, task_count);
				end
				if (want.run_valid)
					runs_handed++;
			end
		end
		if (arst_n && start && !busy) begin
			r.req = req_type; r.handle = task_handle; r.dly = delay;
			r.per = period; r.pos = position;
			expected_outcomes.push_back(schedule_step(r));
			accepted_total++;
			take = 1'b1;
		end
		took_item <= take;
	end

	always @(posedge clk) begin
		if (cycles >= CYCLE_CAP) begin
			$display("timeout after %0d cycles", cycles);
			$display("end of test: mismatches");
			$finish;
		end
	end

	// Drain: wait for every item and result, then allow the longest dispatch latency.
	initial begin
		wait (arst_n);
		wait (pending_reqs.size() == 0 && expected_outcomes.size() == 0);
		repeat (200) @(posedge clk);
		$display("%0d requests taken, %0d tasks handed out to run", accepted_total, runs_handed);
		$display("%0d adds refused on a full list, %0d deletes of an empty position",
			full_hits, empty_deletes);
		if (mismatches == 0 && expected_outcomes.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
